>>> hdl/rsgf64_pkg.sv
// Package for the GF(64) Reed-Solomon encoder: field constants, code sizes,
// parity coefficient tables and the field multiply. No dependencies.
package rsgf64_pkg;

	localparam int SymW   = 6;
	localparam int NParMax = 16;
	localparam int CntW   = 5;
	localparam int ParIdxW = 4;
	localparam logic [SymW:0] FieldPoly = 7'h43;

	typedef logic [SymW-1:0] sym_t;
	typedef sym_t [NParMax-1:0] par_vec_t;

	typedef enum logic [1:0] {
		MODE_A  = 2'd0,
		MODE_B  = 2'd1,
		MODE_C  = 2'd2,
		MODE_X  = 2'd3
	} mode_t;

	// Beat of the output stream.
	typedef struct packed {
		sym_t sym;
		logic parity;
		logic last;
	} out_beat_t;

	// Code geometry for the active mode.
	typedef struct packed {
		logic [CntW-1:0]    k;
		logic [ParIdxW:0]   npar;
	} geom_t;

	function automatic geom_t mode_geom(input mode_t m);
		geom_t g;
		case (m)
			MODE_B: begin
				g.k = 5'd16; g.npar = 5'd8;
			end
			MODE_C: begin
				g.k = 5'd20; g.npar = 5'd16;
			end
			default: begin
				g.k = 5'd12; g.npar = 5'd12;
			end
		endcase
		return g;
	endfunction

	function automatic sym_t gf_mul(input sym_t x, input sym_t y);
		logic [SymW:0] a;
		sym_t acc;
		acc = '0;
		a = {1'b0, x};
		for (int i = 0; i < SymW; i++) begin
			if (y[i]) acc = acc ^ a[SymW-1:0];
			a = {a[SymW-1:0], 1'b0};
			if (a[SymW]) a = a ^ FieldPoly;
		end
		return acc;
	endfunction

	localparam sym_t PAR_A [12][12] = '{
		'{6'o62,6'o44,6'o03,6'o25,6'o14,6'o16,6'o27,6'o03,6'o53,6'o04,6'o36,6'o47},
		'{6'o11,6'o12,6'o11,6'o11,6'o16,6'o64,6'o67,6'o55,6'o01,6'o76,6'o26,6'o73},
		'{6'o03,6'o01,6'o05,6'o75,6'o14,6'o06,6'o20,6'o44,6'o66,6'o06,6'o70,6'o66},
		'{6'o21,6'o70,6'o27,6'o45,6'o16,6'o67,6'o23,6'o64,6'o73,6'o33,6'o44,6'o21},
		'{6'o30,6'o22,6'o03,6'o75,6'o15,6'o15,6'o33,6'o15,6'o51,6'o03,6'o53,6'o50},
		'{6'o01,6'o41,6'o27,6'o56,6'o76,6'o64,6'o21,6'o53,6'o04,6'o25,6'o01,6'o12},
		'{6'o61,6'o76,6'o21,6'o55,6'o76,6'o01,6'o63,6'o35,6'o30,6'o13,6'o64,6'o70},
		'{6'o24,6'o22,6'o71,6'o56,6'o21,6'o35,6'o73,6'o42,6'o57,6'o74,6'o43,6'o76},
		'{6'o72,6'o42,6'o05,6'o20,6'o43,6'o47,6'o33,6'o56,6'o01,6'o16,6'o13,6'o76},
		'{6'o72,6'o14,6'o65,6'o54,6'o35,6'o25,6'o41,6'o16,6'o15,6'o40,6'o71,6'o26},
		'{6'o73,6'o65,6'o36,6'o61,6'o42,6'o22,6'o17,6'o04,6'o44,6'o20,6'o25,6'o05},
		'{6'o71,6'o05,6'o55,6'o03,6'o71,6'o34,6'o60,6'o11,6'o74,6'o02,6'o41,6'o50}};

	localparam sym_t PAR_B [16][8] = '{
		'{6'o51,6'o45,6'o67,6'o15,6'o64,6'o67,6'o52,6'o12},
		'{6'o57,6'o25,6'o63,6'o73,6'o71,6'o22,6'o40,6'o15},
		'{6'o05,6'o01,6'o31,6'o04,6'o16,6'o54,6'o25,6'o76},
		'{6'o73,6'o07,6'o47,6'o14,6'o41,6'o77,6'o47,6'o11},
		'{6'o75,6'o15,6'o51,6'o51,6'o17,6'o67,6'o17,6'o57},
		'{6'o20,6'o32,6'o14,6'o42,6'o75,6'o42,6'o70,6'o54},
		'{6'o02,6'o75,6'o43,6'o05,6'o01,6'o40,6'o12,6'o64},
		'{6'o24,6'o74,6'o15,6'o72,6'o24,6'o26,6'o74,6'o61},
		'{6'o42,6'o64,6'o07,6'o22,6'o61,6'o20,6'o40,6'o65},
		'{6'o32,6'o32,6'o55,6'o41,6'o57,6'o66,6'o21,6'o77},
		'{6'o65,6'o36,6'o25,6'o07,6'o50,6'o16,6'o40,6'o51},
		'{6'o64,6'o06,6'o54,6'o32,6'o76,6'o46,6'o14,6'o36},
		'{6'o62,6'o63,6'o74,6'o70,6'o05,6'o27,6'o37,6'o46},
		'{6'o55,6'o43,6'o34,6'o71,6'o57,6'o76,6'o50,6'o64},
		'{6'o24,6'o23,6'o23,6'o05,6'o50,6'o70,6'o42,6'o23},
		'{6'o67,6'o75,6'o45,6'o60,6'o57,6'o24,6'o06,6'o26}};

	localparam sym_t PAR_C [20][16] = '{
		'{6'o74,6'o37,6'o34,6'o06,6'o02,6'o07,6'o44,6'o64,6'o26,6'o14,6'o26,6'o44,6'o54,6'o13,6'o77,6'o05},
		'{6'o04,6'o17,6'o50,6'o24,6'o11,6'o05,6'o30,6'o57,6'o33,6'o03,6'o02,6'o02,6'o15,6'o16,6'o25,6'o26},
		'{6'o07,6'o23,6'o37,6'o46,6'o56,6'o75,6'o43,6'o45,6'o55,6'o21,6'o50,6'o31,6'o45,6'o27,6'o71,6'o62},
		'{6'o26,6'o05,6'o07,6'o63,6'o63,6'o27,6'o63,6'o40,6'o06,6'o04,6'o40,6'o45,6'o47,6'o30,6'o75,6'o07},
		'{6'o23,6'o73,6'o73,6'o41,6'o72,6'o34,6'o21,6'o51,6'o67,6'o16,6'o31,6'o74,6'o11,6'o21,6'o12,6'o21},
		'{6'o24,6'o51,6'o25,6'o23,6'o22,6'o41,6'o74,6'o66,6'o74,6'o65,6'o70,6'o36,6'o67,6'o45,6'o64,6'o01},
		'{6'o52,6'o33,6'o14,6'o02,6'o20,6'o06,6'o14,6'o25,6'o52,6'o23,6'o35,6'o74,6'o75,6'o75,6'o43,6'o27},
		'{6'o55,6'o62,6'o56,6'o25,6'o73,6'o60,6'o15,6'o30,6'o13,6'o17,6'o20,6'o02,6'o70,6'o55,6'o14,6'o47},
		'{6'o54,6'o51,6'o32,6'o65,6'o77,6'o12,6'o54,6'o13,6'o35,6'o32,6'o56,6'o12,6'o75,6'o01,6'o72,6'o63},
		'{6'o74,6'o41,6'o30,6'o41,6'o43,6'o22,6'o51,6'o06,6'o64,6'o33,6'o03,6'o47,6'o27,6'o12,6'o55,6'o47},
		'{6'o54,6'o70,6'o11,6'o03,6'o13,6'o22,6'o16,6'o57,6'o03,6'o45,6'o72,6'o31,6'o30,6'o56,6'o35,6'o22},
		'{6'o51,6'o07,6'o72,6'o30,6'o65,6'o54,6'o06,6'o21,6'o36,6'o63,6'o50,6'o61,6'o64,6'o52,6'o01,6'o60},
		'{6'o01,6'o65,6'o32,6'o70,6'o13,6'o44,6'o73,6'o24,6'o12,6'o52,6'o21,6'o55,6'o12,6'o35,6'o14,6'o72},
		'{6'o11,6'o70,6'o05,6'o10,6'o65,6'o24,6'o15,6'o77,6'o22,6'o24,6'o24,6'o74,6'o07,6'o44,6'o07,6'o46},
		'{6'o06,6'o02,6'o65,6'o11,6'o41,6'o20,6'o45,6'o42,6'o46,6'o54,6'o35,6'o12,6'o40,6'o64,6'o65,6'o33},
		'{6'o34,6'o31,6'o01,6'o15,6'o44,6'o64,6'o16,6'o24,6'o52,6'o16,6'o06,6'o62,6'o20,6'o13,6'o55,6'o57},
		'{6'o63,6'o43,6'o25,6'o44,6'o77,6'o63,6'o17,6'o17,6'o64,6'o14,6'o40,6'o74,6'o31,6'o72,6'o54,6'o06},
		'{6'o71,6'o21,6'o70,6'o44,6'o56,6'o04,6'o30,6'o74,6'o04,6'o23,6'o71,6'o70,6'o63,6'o45,6'o56,6'o43},
		'{6'o02,6'o01,6'o53,6'o74,6'o02,6'o14,6'o52,6'o74,6'o12,6'o57,6'o24,6'o63,6'o15,6'o42,6'o52,6'o33},
		'{6'o34,6'o35,6'o02,6'o23,6'o21,6'o27,6'o22,6'o33,6'o64,6'o42,6'o05,6'o73,6'o51,6'o46,6'o73,6'o60}};

	// Coefficient of the given row and parity column for a mode; zero past npar.
	function automatic sym_t coef(input mode_t m, input logic [CntW-1:0] row,
			input logic [ParIdxW-1:0] col);
		sym_t c;
		c = '0;
		case (m)
			MODE_B: if (row < 5'd16 && col < 4'd8) c = PAR_B[row[3:0]][col[2:0]];
			MODE_C: if (row < 5'd20) c = PAR_C[row][col];
			default: if (row < 5'd12 && col < 4'd12) c = PAR_A[row[3:0]][col];
		endcase
		return c;
	endfunction

endpackage

>>> hdl/rsgf64_if.sv
// Valid/ready stream interface for symbol beats.
// Depends on nothing; payload width is a parameter.
interface rsgf64_stream_if #(parameter int W = 6);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rsgf64_acc.sv
// Parity accumulator bank: constant GF(64) multiplies XORed into the row.
// Depends on rsgf64_pkg.
module rsgf64_acc import rsgf64_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     clr,
	input  logic     load,
	input  logic     done,
	input  mode_t    mode,
	input  logic [CntW-1:0] row,
	input  sym_t     sym,
	output par_vec_t par_next
);
	par_vec_t acc_q;

	always_comb begin
		for (int p = 0; p < NParMax; p++)
			par_next[p] = acc_q[p] ^ gf_mul(sym, coef(mode, row, ParIdxW'(p)));
	end

	// Drop the block on clear or after the last data symbol.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr || (load && done)) begin
			acc_q <= '0;
		end else if (load) begin
			acc_q <= par_next;
		end
	end
endmodule

>>> hdl/rs_gf64_systematic_encoder.sv
// Top level of the GF(64) Reed-Solomon systematic encoder.
// Depends on rsgf64_pkg, rsgf64_stream_if and rsgf64_acc.
//
// channel   dir  payload
// in_s      in   data_symbol[5:0]
// out_s     out  {code_symbol[5:0], is_parity, block_end}
// cfg       in   code_mode[1:0] write, no read-back
//
// One data beat is taken per cycle when not stalled; its echo leaves from the
// result register in the next cycle. The beat that completes a block loads
// the parity vector into a read-out buffer, and the n-k parity beats follow
// one a cycle when not stalled; no new data is taken while they drain. Reset
// clears the mode, counter and accumulators; a mode write drops the current
// block. A stalled output holds its beat and backs input ready off.
module rs_gf64_systematic_encoder import rsgf64_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rsgf64_stream_if.sink     in_s,
	rsgf64_stream_if.source   out_s,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata
);
	mode_t           mode_q;
	logic [CntW-1:0] cnt_q;
	par_vec_t        par_q;
	logic [ParIdxW:0] drain_q;     // parity beats still to send
	logic [ParIdxW-1:0] rd_q;      // next parity index
	logic            ov_q;
	out_beat_t       ob_q;
	geom_t           geom;
	par_vec_t        par_next;
	logic            take, done, adv;

	assign geom = mode_geom(mode_q);
	assign adv  = !ov_q || out_s.ready;
	// Hold input while parity drains.
	assign in_s.ready = adv && (drain_q == '0);
	assign take = in_s.valid && in_s.ready;
	assign done = (cnt_q + 5'd1) >= geom.k;

	rsgf64_acc u_acc (
		.clk(clk), .arst_n(arst_n), .clr(cfg_we), .load(take), .done(done),
		.mode(mode_q), .row(cnt_q), .sym(in_s.data), .par_next(par_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_A;
			cnt_q   <= '0;
			drain_q <= '0;
			rd_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (adv) ov_q <= take || (drain_q != '0);
			if (cfg_we) begin
				mode_q  <= mode_t'(cfg_wdata);
				cnt_q   <= '0;
			end else if (take) begin
				cnt_q <= done ? '0 : cnt_q + 5'd1;
			end
			if (take && done) begin
				drain_q <= geom.npar;
				rd_q    <= '0;
			end else if (adv && drain_q != '0) begin
				drain_q <= drain_q - 5'd1;
				rd_q    <= rd_q + 4'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take && done) par_q <= par_next;
		if (adv) begin
			if (take) begin
				ob_q <= '{sym: in_s.data, parity: 1'b0, last: 1'b0};
			end else begin
				ob_q <= '{sym: par_q[rd_q], parity: 1'b1,
					last: (drain_q == 5'd1)};
			end
		end
	end

	assign out_s.valid = ov_q;
	assign out_s.data  = ob_q;

`ifndef SYNTHESIS
	a_no_take_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q != '0) |-> !in_s.ready) else $error("input taken during parity");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < geom.k) else $error("counter past k");
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && done) |=> (drain_q == $past(geom.npar))) else $error("drain load");
`endif
endmodule
